>>> hdl/cac_pkg.sv
package cac_pkg;

    // Coordinate width of the display position fields
    localparam int COORD_BITS = 12;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_TYPE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_SIZE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPACITY    = 2'd2;

    // Pixel modes
    localparam logic [1:0] MODE_RGB        = 2'd0;
    localparam logic [1:0] MODE_RGB_ALPHA  = 2'd1;
    localparam logic [1:0] MODE_GRAY       = 2'd2;
    localparam logic [1:0] MODE_GRAY_ALPHA = 2'd3;

    // Check sizes
    localparam logic [1:0] SIZE_FOUR    = 2'd0;
    localparam logic [1:0] SIZE_EIGHT   = 2'd1;

    // Check pairs
    localparam logic [2:0] CHECK_GRAY_LIGHT = 3'd0;
    localparam logic [2:0] CHECK_GRAY_MID   = 3'd1;
    localparam logic [2:0] CHECK_GRAY_DARK  = 3'd2;
    localparam logic [2:0] CHECK_WHITE      = 3'd3;
    localparam logic [2:0] CHECK_GRAY       = 3'd4;

    // Load enables of the pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    // floor(p / 255), exact for p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    // Check value for a pair and a square parity (1 selects the dark value)
    function automatic logic [7:0] check_value(input logic [2:0] ct, input logic dark);
        logic [7:0] v;
        case (ct)
            CHECK_GRAY_LIGHT: v = dark ? 8'd204 : 8'd255;
            CHECK_GRAY_MID:   v = dark ? 8'd102 : 8'd153;
            CHECK_GRAY_DARK:  v = dark ? 8'd0   : 8'd51;
            CHECK_WHITE:      v = 8'd255;
            CHECK_GRAY:       v = 8'd127;
            default:          v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/cac_alpha.sv
module cac_alpha (
    input  logic                          i_clk,
    input  cac_pkg::t_pipe_en             i_en,
    input  logic [1:0]                    i_mode,
    input  logic [cac_pkg::COORD_BITS-1:0] i_pixel_x,
    input  logic [cac_pkg::COORD_BITS-1:0] i_pixel_y,
    input  logic [7:0]                    i_red_in,
    input  logic [7:0]                    i_green_in,
    input  logic [7:0]                    i_blue_in,
    input  logic [7:0]                    i_alpha_in,
    input  logic [2:0]                    i_check_type,
    input  logic [1:0]                    i_check_size,
    input  logic [7:0]                    i_opacity,
    output logic [7:0]                    o_ea,
    output logic [7:0]                    o_chk,
    output logic                          o_blend,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);

    logic        gray;
    logic        dark;
    logic [15:0] r_prod;
    logic [7:0]  r_chk1;
    logic        r_blend1;
    logic [7:0]  r_red1, r_green1, r_blue1;
    logic [7:0]  r_ea2, r_chk2;
    logic        r_blend2;
    logic [7:0]  r_red2, r_green2, r_blue2;

    assign gray = (i_mode == cac_pkg::MODE_GRAY) || (i_mode == cac_pkg::MODE_GRAY_ALPHA);

    // Square parity: bit s of x plus bit s of y
    always_comb begin
        case (i_check_size)
            cac_pkg::SIZE_FOUR:  dark = i_pixel_x[2] ^ i_pixel_y[2];
            cac_pkg::SIZE_EIGHT: dark = i_pixel_x[3] ^ i_pixel_y[3];
            default:             dark = i_pixel_x[4] ^ i_pixel_y[4];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod   <= {8'd0, i_opacity} * {8'd0, i_alpha_in};
            r_chk1   <= cac_pkg::check_value(i_check_type, dark);
            r_blend1 <= (i_mode == cac_pkg::MODE_RGB_ALPHA) ||
                        (i_mode == cac_pkg::MODE_GRAY_ALPHA);
            r_red1   <= i_red_in;
            r_green1 <= gray ? i_red_in : i_green_in;
            r_blue1  <= gray ? i_red_in : i_blue_in;
        end
        if (i_en.s2) begin
            r_ea2    <= cac_pkg::div255(r_prod);
            r_chk2   <= r_chk1;
            r_blend2 <= r_blend1;
            r_red2   <= r_red1;
            r_green2 <= r_green1;
            r_blue2  <= r_blue1;
        end
    end

    assign o_ea    = r_ea2;
    assign o_chk   = r_chk2;
    assign o_blend = r_blend2;
    assign o_red   = r_red2;
    assign o_green = r_green2;
    assign o_blue  = r_blue2;

endmodule

>>> hdl/cac_lane.sv
module cac_lane (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_color,
    input  logic [7:0] i_ea,
    input  logic [7:0] i_chk,
    input  logic       i_blend,
    output logic [7:0] o_color
);

    logic [15:0] r_sum;
    logic [7:0]  r_color;
    logic        r_blend;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= ({8'd0, i_color} * {8'd0, i_ea}) +
                       ({8'd0, i_chk} * {8'd0, 8'd255 - i_ea});
            r_color <= i_color;
            r_blend <= i_blend;
        end
    end

    // Pass the sample through when it carries no alpha
    assign o_color = r_blend ? cac_pkg::div255(r_sum) : r_color;

endmodule

>>> hdl/checkerboard_alpha_composite_unit.sv
// Channel   Direction  Handshake            Payload
// pixel     in         i_valid / o_stall    i_mode, i_pixel_x/y, i_*_in
// display   out        o_valid / i_stall    o_red_out, o_green_out, o_blue_out
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One pixel per clock while the output is not stalled; from input transfer
// to output valid each pixel passes the alpha product, effective alpha,
// per-channel blend sums in three lanes, then the merged output register.
// Reset is synchronous, active low; it clears the stage valid bits and loads
// the register reset values.
// A stall moves backward only as far as the first empty stage, so bubbles
// are filled while the output waits.
module checkerboard_alpha_composite_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cac_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [cac_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_mode,
    input  logic [cac_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  logic [cac_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  logic [7:0]                          i_red_in,
    input  logic [7:0]                          i_green_in,
    input  logic [7:0]                          i_blue_in,
    input  logic [7:0]                          i_alpha_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [7:0]                          o_red_out,
    output logic [7:0]                          o_green_out,
    output logic [7:0]                          o_blue_out
);

    // Configuration registers
    logic [2:0] r_check_type;
    logic [1:0] r_check_size;
    logic [7:0] r_opacity;

    // Stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    cac_pkg::t_pipe_en en;

    logic [7:0] ea, chk;
    logic       blend;
    logic [7:0] red2, green2, blue2;
    logic [7:0] red3, green3, blue3;
    logic [7:0] r_red_out, r_green_out, r_blue_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_type <= 3'd0;
            r_check_size <= 2'd1;
            r_opacity    <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cac_pkg::REG_CHECK_TYPE: r_check_type <= i_cfg_data[2:0];
                cac_pkg::REG_CHECK_SIZE: r_check_size <= i_cfg_data[1:0];
                cac_pkg::REG_OPACITY:    r_opacity    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its content moves on
    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    cac_alpha u_alpha (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_mode       (i_mode),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .i_check_type (r_check_type),
        .i_check_size (r_check_size),
        .i_opacity    (r_opacity),
        .o_ea         (ea),
        .o_chk        (chk),
        .o_blend      (blend),
        .o_red        (red2),
        .o_green      (green2),
        .o_blue       (blue2)
    );

    // One blend lane per color channel
    cac_lane u_lane_red (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_color (red2),
        .i_ea    (ea),
        .i_chk   (chk),
        .i_blend (blend),
        .o_color (red3)
    );

    cac_lane u_lane_green (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_color (green2),
        .i_ea    (ea),
        .i_chk   (chk),
        .i_blend (blend),
        .o_color (green3)
    );

    cac_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_en    (en.s3),
        .i_color (blue2),
        .i_ea    (ea),
        .i_chk   (chk),
        .i_blend (blend),
        .o_color (blue3)
    );

    // Merge the lanes into the output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_red_out   <= red3;
            r_green_out <= green3;
            r_blue_out  <= blue3;
        end
    end

    assign o_valid     = r_v4;
    assign o_red_out   = r_red_out;
    assign o_green_out = r_green_out;
    assign o_blue_out  = r_blue_out;

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_v3 && !r_v4) |-> !o_stall)
        else $error("empty pipeline refuses a pixel");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted pixel lost at first stage");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_stall && !r_v3) |=> !o_valid)
        else $error("output valid without a pixel behind it");

    a_lane_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !(r_v4 && i_stall)) |=> o_valid)
        else $error("blended pixel did not reach the output");

endmodule

>>> dv/tb.sv
module tb;

    // Codes the package does not name
    localparam logic [2:0]                       CHECK_BLACK  = 3'd5;
    localparam logic [1:0]                       SIZE_SIXTEEN = 2'd2;
    localparam logic [cac_pkg::CFG_IDX_BITS-1:0] REG_SPARE    = 2'd3;

    localparam int N_PHASES     = 8;
    localparam int RAND_PER_PH  = 192;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;

    // One pixel as offered on the input channel
    typedef struct packed {
        logic [1:0]                     mode;
        logic [cac_pkg::COORD_BITS-1:0] x;
        logic [cac_pkg::COORD_BITS-1:0] y;
        logic [7:0]                     red;
        logic [7:0]                     green;
        logic [7:0]                     blue;
        logic [7:0]                     alpha;
    } t_pixel;

    // One display pixel as seen on the output channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_display;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              i_cfg_we   = 1'b0;
    logic [cac_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [cac_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    logic   i_valid = 1'b0;
    logic   o_stall;
    t_pixel pix_drv = '0;

    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;

    // Shadow copy of the layer registers, reset values to start
    logic [2:0] cfg_type    = cac_pkg::CHECK_GRAY_LIGHT;
    logic [1:0] cfg_size    = cac_pkg::SIZE_EIGHT;
    logic [7:0] cfg_opacity = 8'd255;

    t_pixel   pixel_q[$];
    t_display display_q[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int pixels_sent     = 0;
    int displays_seen   = 0;
    int fail_count      = 0;
    int holds_done      = 0;
    int settings_used   = 1;

    int unsigned xfer_cnt  = 0;
    int unsigned hold_left = 0;

    checkerboard_alpha_composite_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (pix_drv.mode),
        .i_pixel_x   (pix_drv.x),
        .i_pixel_y   (pix_drv.y),
        .i_red_in    (pix_drv.red),
        .i_green_in  (pix_drv.green),
        .i_blue_in   (pix_drv.blue),
        .i_alpha_in  (pix_drv.alpha),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lay one channel over the check value with the effective alpha
    function automatic logic [7:0] over_check(input logic [7:0] c, input int unsigned ea,
                                              input int unsigned chk);
        int unsigned sum;
        sum = c * ea + chk * (255 - ea);
        return 8'(sum / 255);
    endfunction

    // Expected display pixel for one input pixel under the current layer registers
    function automatic t_display composite(input t_pixel p);
        t_display    d;
        logic [2:0]  pair;
        int unsigned shift;
        int unsigned ea;
        int unsigned chk;
        logic        dark;
        d.red   = p.red;
        d.green = p.green;
        d.blue  = p.blue;
        // Gray modes spread the one value over all three channels
        if (p.mode == cac_pkg::MODE_GRAY || p.mode == cac_pkg::MODE_GRAY_ALPHA) begin
            d.green = p.red;
            d.blue  = p.red;
        end
        if (p.mode == cac_pkg::MODE_RGB_ALPHA || p.mode == cac_pkg::MODE_GRAY_ALPHA) begin
            // Out-of-range pair and size codes saturate to the last entry
            pair  = (cfg_type > CHECK_BLACK) ? CHECK_BLACK : cfg_type;
            shift = ((cfg_size > SIZE_SIXTEEN) ? SIZE_SIXTEEN : cfg_size) + 2;
            ea    = (cfg_opacity * p.alpha) / 255;
            dark  = 1'((p.x >> shift) + (p.y >> shift));
            case (pair)
                cac_pkg::CHECK_GRAY_LIGHT: chk = dark ? 204 : 255;
                cac_pkg::CHECK_GRAY_MID:   chk = dark ? 102 : 153;
                cac_pkg::CHECK_GRAY_DARK:  chk = dark ? 0   : 51;
                cac_pkg::CHECK_WHITE:      chk = 255;
                cac_pkg::CHECK_GRAY:       chk = 127;
                default:                   chk = 0;
            endcase
            d.red   = over_check(d.red,   ea, chk);
            d.green = over_check(d.green, ea, chk);
            d.blue  = over_check(d.blue,  ea, chk);
        end
        return d;
    endfunction

    // Sender: predict on each transfer, then offer the next pixel or go idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                display_q.push_back(composite(pix_drv));
                pixels_sent++;
            end
            // Hold the payload while stalled; otherwise advance or drop valid
            if (!i_valid || !o_stall) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    pix_drv <= pixel_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold: every 400 transfers, stall the output for a fixed stretch
    // while the sender keeps offering, so the pipe fills and backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            xfer_cnt  <= 0;
            hold_left <= 0;
        end else begin
            if (i_valid && !o_stall)
                xfer_cnt <= xfer_cnt + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (i_valid && !o_stall && xfer_cnt % 400 == 100) begin
                hold_left <= HOLD_CYCLES;
                holds_done++;
            end
        end
    end

    // Receiver: check every display transfer against the oldest prediction
    always @(posedge i_clk) begin : display_check
        t_display got;
        t_display want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_red_out, o_green_out, o_blue_out};
                displays_seen++;
                if (display_q.size() == 0) begin
                    $error("display transfer with nothing pending: %0d/%0d/%0d",
                           got.red, got.green, got.blue);
                    fail_count++;
                end else begin
                    want = display_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("red_out: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green_out: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_pixel(input logic [1:0] mode, input int x, input int y,
                             input int r, input int g, input int b, input int a);
        t_pixel p;
        p.mode  = mode;
        p.x     = cac_pkg::COORD_BITS'(x);
        p.y     = cac_pkg::COORD_BITS'(y);
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        p.alpha = 8'(a);
        pixel_q.push_back(p);
    endtask

    // Mostly uniform, with the rails drawn often
    function automatic int channel_value();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0)
            return 0;
        else if (pick == 1)
            return 255;
        return $urandom_range(255);
    endfunction

    // Registers are to be written only while the pipe is empty; the unit itself does not enforce it
    task automatic write_reg(input logic [cac_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [cac_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cac_pkg::REG_CHECK_TYPE: cfg_type    = data[2:0];
            cac_pkg::REG_CHECK_SIZE: cfg_size    = data[1:0];
            cac_pkg::REG_OPACITY:    cfg_opacity = data;
            default:                 ;
        endcase
    endtask

    // Sender waits until every pending display pixel has come back
    task automatic wait_drained();
        while (pixel_q.size() != 0 || i_valid || display_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        // Per phase: pair code, size code, opacity, idle style
        // (0 none, 1 sender idle, 2 receiver stalls, 3 both)
        int ph_type[N_PHASES] = '{0, 1, 2, 3, 4, 5, 6, 7};
        int ph_size[N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
        int ph_opac[N_PHASES] = '{255, 128, 0, 1, 200, 254, 77, 255};
        int ph_idle[N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels at the reset register values (light gray pair, 8-pixel checks)
        add_pixel(cac_pkg::MODE_RGB,        0,    0,    0,   0,   0,   255);
        add_pixel(cac_pkg::MODE_RGB,        4095, 4095, 255, 255, 255, 0);
        add_pixel(cac_pkg::MODE_GRAY,       0,    4095, 255, 0,   77,  0);
        add_pixel(cac_pkg::MODE_GRAY,       4095, 0,    0,   255, 255, 255);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  0,    0,    255, 0,   128, 0);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  8,    0,    255, 0,   128, 0);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  4095, 4095, 255, 0,   1,   255);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  4095, 0,    0,   255, 255, 128);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  0,    4095, 17,  200, 99,  1);
        add_pixel(cac_pkg::MODE_GRAY_ALPHA, 7,    8,    200, 3,   9,   0);
        add_pixel(cac_pkg::MODE_GRAY_ALPHA, 8,    8,    0,   255, 255, 255);
        add_pixel(cac_pkg::MODE_GRAY_ALPHA, 4095, 7,    255, 0,   0,   127);
        add_pixel(cac_pkg::MODE_RGB_ALPHA,  2730, 1365, 255, 255, 255, 254);
        add_pixel(cac_pkg::MODE_GRAY_ALPHA, 1365, 2730, 0,   0,   0,   254);
        add_pixel(cac_pkg::MODE_RGB,        2730, 1365, 170, 85,  170, 85);
        add_pixel(cac_pkg::MODE_GRAY,       1365, 2730, 85,  170, 85,  170);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Stray upper bits in the write data must be dropped
            write_reg(cac_pkg::REG_CHECK_TYPE, {5'($urandom_range(31)), 3'(ph_type[ph])});
            write_reg(cac_pkg::REG_CHECK_SIZE, {6'($urandom_range(63)), 2'(ph_size[ph])});
            write_reg(cac_pkg::REG_OPACITY,    8'(ph_opac[ph]));
            if (ph == 3)
                write_reg(REG_SPARE, 8'($urandom_range(255)));
            settings_used++;

            sender_idle_pct = (ph_idle[ph] == 1) ? 61 : (ph_idle[ph] == 3) ? 30 : 0;
            recv_stall_pct  = (ph_idle[ph] == 2) ? 61 : (ph_idle[ph] == 3) ? 30 : 0;

            for (n = 0; n < RAND_PER_PH; n++)
                add_pixel(2'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095),
                          channel_value(), channel_value(), channel_value(), channel_value());
            wait_drained();
        end

        $display("covered %0d pixels (%0d displayed) over %0d register settings",
                 pixels_sent, displays_seen, settings_used);
        $display("all four modes, every pair and size code, %0d long output holds",
                 holds_done);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
